[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/gii_pkg.sv]
// Package with the widths, constants and gray conversion of the integral image unit.
`default_nettype none

package gii_pkg;

    localparam int unsigned LINE_WIDTH_W = 12;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned GRAY_W       = 8;
    localparam int unsigned SUM_W        = 32;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd640;

    // Division by 100 is done as a multiply by 5243 and a right shift by 19,
    // which is exact for every dividend below 43699. The weight is folded in.
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = BYTE_W + RECIP_SHIFT;
    localparam logic [PROD_W-1:0] K_FIRST  = 27'd309337;  // 59 * 5243
    localparam logic [PROD_W-1:0] K_SECOND = 27'd157290;  // 30 * 5243
    localparam logic [PROD_W-1:0] K_THIRD  = 27'd57673;   // 11 * 5243

    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [GRAY_W-1:0] gray_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // One weighted term, truncated on its own: floor(b * weight / 100).
    function automatic byte_t weighted_term(input byte_t b, input logic [PROD_W-1:0] k);
        logic [PROD_W-1:0] prod;
        prod = {{RECIP_SHIFT{1'b0}}, b} * k;
        return prod[PROD_W-1:RECIP_SHIFT];
    endfunction

    // The three terms sum to at most 254, so eight bits hold the result.
    function automatic gray_t to_gray(input byte_t b0, input byte_t b1, input byte_t b2);
        logic [GRAY_W:0] total;
        total = {1'b0, weighted_term(b0, K_FIRST)} + {1'b0, weighted_term(b1, K_SECOND)}
              + {1'b0, weighted_term(b2, K_THIRD)};
        return total[GRAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/gii_pixel_if.sv]
// Valid/ready channel that carries one pixel word into the integral image unit.
`default_nettype none

interface gii_pixel_if;
    import gii_pkg::*;

    logic  valid;
    logic  ready;
    logic  frame_start;
    byte_t byte_first;
    byte_t byte_second;
    byte_t byte_third;

    modport source (output valid, frame_start, byte_first, byte_second, byte_third,
                    input ready);
    modport sink   (input valid, frame_start, byte_first, byte_second, byte_third,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/gii_result_if.sv]
// Valid/ready channel that carries one result word out of the integral image unit.
`default_nettype none

interface gii_result_if;
    import gii_pkg::*;

    logic  valid;
    logic  ready;
    gray_t gray_value;
    sum_t  integral_sum;
    logic  row_last;

    modport source (output valid, gray_value, integral_sum, row_last, input ready);
    modport sink   (input valid, gray_value, integral_sum, row_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/gii_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gii_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/grayscale_integral_image_unit.sv]
// Top level of the grayscale integral image (summed-area table) unit.
//
// The unit takes 3-byte pixel words in raster order, one per clock when both
// sides keep up, and returns for each pixel its gray value (the three bytes
// weighted 59/100, 30/100 and 11/100, each term truncated) together with its
// integral value: the sum of the gray values of all pixels above and to the
// left of it, itself included, modulo 2^32. A result word passes through
// stage 1, which waits on the registered read of the line store holding the
// integral values of the previous row, then through the output register. The
// rate is one pixel per cycle while both sides keep up: the line store is read
// at accept, written back as stage 1 moves on, and a write to the address being
// read in the same cycle (rows of one pixel) is forwarded past the memory.
// frame_start on a pixel restarts the image at that pixel; the first row of an
// image sees the row above as zero. line_width sets the pixels per row; a value
// of 0 acts as 1 and a value above MAX_WIDTH acts as MAX_WIDTH. Narrowing the
// width in mid-row ends the current row at the pixel being taken. The line
// store is not cleared after reset; only entries written since reset are read
// as long as the width does not grow within a frame. line_width must be written
// only while the unit is idle.
`default_nettype none
`include "assert_macros.svh"

module grayscale_integral_image_unit #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gii_pkg::LINE_WIDTH_W-1:0] cfg_wr_data,
    gii_pixel_if.sink                          pix,
    gii_result_if.source                       res
);
    import gii_pkg::*;

    localparam int unsigned AddrW = $clog2(MAX_WIDTH);
    // Width wide enough to hold both the configured width and MAX_WIDTH.
    localparam int unsigned CmpW  = (AddrW + 1 > LINE_WIDTH_W) ? AddrW + 1 : LINE_WIDTH_W;

    // Configuration and per-row control state.
    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [AddrW-1:0]        col_reg;
    logic [AddrW-1:0]        col_next;
    logic                    first_row_reg;
    logic                    first_row_next;

    // Stage 1: pixel waiting for its line store read data.
    logic             s1_valid_reg;
    logic [AddrW-1:0] s1_col_reg;
    gray_t            s1_gray_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;

    // Forwarding of a write that hit the address read in the same cycle.
    logic fwd_valid_reg;
    sum_t fwd_data_reg;

    // Running sum of the current row, updated as words leave stage 1.
    sum_t row_sum_reg;

    // Output register.
    logic  out_valid_reg;
    gray_t out_gray_reg;
    sum_t  out_sum_reg;
    logic  out_last_reg;

    logic             in_accept;
    logic             s1_advance;
    logic [AddrW-1:0] col_eff;
    logic             first_eff;
    logic [CmpW-1:0]  width_eff;
    logic             last_now;
    sum_t             ram_rdata;
    sum_t             above;
    sum_t             row_sum_new;
    sum_t             integral;

    // Effective width: zero acts as one, anything above MAX_WIDTH is clamped.
    always_comb
    begin
        if (line_width_reg == '0)
        begin
            width_eff = CmpW'(1);
        end
        else if (CmpW'(line_width_reg) > CmpW'(MAX_WIDTH))
        begin
            width_eff = CmpW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = CmpW'(line_width_reg);
        end
    end

    // Stage 1 leaves when the output register is empty or being drained.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pix.ready  = !s1_valid_reg || s1_advance;
    assign in_accept  = pix.valid && pix.ready;

    // A frame start restarts the row and the frame before the pixel is placed.
    assign col_eff   = pix.frame_start ? '0 : col_reg;
    assign first_eff = pix.frame_start ? 1'b1 : first_row_reg;
    assign last_now  = (CmpW'(col_eff) + CmpW'(1)) >= width_eff;

    assign col_next       = last_now ? '0 : AddrW'(CmpW'(col_eff) + CmpW'(1));
    assign first_row_next = last_now ? 1'b0 : first_eff;

    gii_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (integral),
        .re    (in_accept),
        .raddr (col_eff),
        .rdata (ram_rdata)
    );

    // Column zero always opens a row, so the running sum restarts there.
    assign row_sum_new = ((s1_col_reg == '0) ? '0 : row_sum_reg) + SUM_W'(s1_gray_reg);
    always_comb
    begin
        if (s1_first_reg)
        begin
            above = '0;
        end
        else if (fwd_valid_reg)
        begin
            above = fwd_data_reg;
        end
        else
        begin
            above = ram_rdata;
        end
    end
    assign integral = row_sum_new + above;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            col_reg        <= '0;
            first_row_reg  <= 1'b1;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            row_sum_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_width_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                col_reg       <= col_next;
                first_row_reg <= first_row_next;
                fwd_valid_reg <= s1_advance && (s1_col_reg == col_eff);
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                row_sum_reg   <= row_sum_new;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg   <= col_eff;
            s1_gray_reg  <= to_gray(pix.byte_first, pix.byte_second, pix.byte_third);
            s1_first_reg <= first_eff;
            s1_last_reg  <= last_now;
            fwd_data_reg <= integral;
        end
        if (s1_advance)
        begin
            out_gray_reg <= s1_gray_reg;
            out_sum_reg  <= integral;
            out_last_reg <= s1_last_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.gray_value   = out_gray_reg;
    assign res.integral_sum = out_sum_reg;
    assign res.row_last     = out_last_reg;

    // The column counter never points past the line store.
    `ASSERT_IMPL(a_col_range, 1'b1, col_reg <= AddrW'(MAX_WIDTH - 1))
    // A pixel that ends a row sends the next one to column zero of a later row.
    `ASSERT_NEXT(a_row_wrap, in_accept && last_now, col_reg == '0 && !first_row_reg)
    // A stalled stage 1 keeps its word and its line store address.
    `ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_col_reg))
    // No pixel is taken while stage 1 is full and cannot move on.
    `ASSERT_IMPL(a_no_overrun, s1_valid_reg && !s1_advance, !pix.ready)

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the grayscale integral image unit.
`timescale 1ns / 100ps

module tb;
    import gii_pkg::*;

    // Depth of the line store, matched to the parameter handed to the unit.
    localparam int unsigned LINE_STORE_DEPTH = 2048;
    // Least number of pixel words sent in the randomized frames.
    localparam int unsigned RANDOM_PIXELS    = 850;

    // One predicted result word, in the field order of the result channel.
    typedef struct packed {
        gray_t gray_value;
        sum_t  integral_sum;
        logic  row_last;
    } pixel_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [LINE_WIDTH_W-1:0] cfg_wr_data;

    gii_pixel_if  pix_if ();
    gii_result_if res_if ();

    grayscale_integral_image_unit #(
        .MAX_WIDTH (LINE_STORE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix         (pix_if),
        .res         (res_if)
    );

    // The clock toggles every 5 ns, which gives a 10 ns period.
    always #5 clk = ~clk;

    // Predicted results that have not yet come out of the unit, oldest first.
    pixel_result_t pending_results[$];
    int            errors = 0;

    // When this is cleared, neither side of the unit inserts idle cycles.
    bit            idle_enabled = 1'b1;

    // The testbench's own copy of the unit's state. It is advanced once for
    // every pixel word that the unit accepts.
    logic [LINE_WIDTH_W-1:0] model_width;
    sum_t                    row_sum;
    int unsigned             next_col;
    bit                      top_row;
    sum_t                    above_row_sums [LINE_STORE_DEPTH];
    bit                      above_row_known [LINE_STORE_DEPTH];

    // The width register is taken as 1 when it is zero, and it is capped at
    // the depth of the line store.
    function automatic int unsigned effective_width();
        int unsigned w;
        w = model_width;
        if (w == 0)
            w = 1;
        if (w > LINE_STORE_DEPTH)
            w = LINE_STORE_DEPTH;
        return w;
    endfunction

    // This is true when a pixel sent without frame_start would read a line
    // store entry that has not been written since reset. That can only happen
    // after the width grows inside a frame, and the stimulus never lets it.
    function automatic bit reads_unwritten_entry();
        int unsigned col;
        col = next_col;
        if (col >= LINE_STORE_DEPTH)
            col = LINE_STORE_DEPTH - 1;
        return !top_row && !above_row_known[col];
    endfunction

    // This task works out the gray value and the summed-area value of one
    // accepted pixel. It then queues the result word that should follow.
    task automatic predict_pixel(input logic fs, input byte_t b0, input byte_t b1,
                                 input byte_t b2);
        int unsigned   w;
        int unsigned   col;
        int unsigned   gray;
        sum_t          above;
        pixel_result_t r;
        w = effective_width();
        if (fs)
        begin
            next_col = 0;
            row_sum  = '0;
            top_row  = 1'b1;
        end
        // Each weighted term is truncated on its own before the three are added.
        gray = (int'(b0) * 59) / 100 + (int'(b1) * 30) / 100 + (int'(b2) * 11) / 100;
        col = next_col;
        if (col >= LINE_STORE_DEPTH)
            col = LINE_STORE_DEPTH - 1;
        row_sum = row_sum + sum_t'(gray);
        above   = top_row ? '0 : above_row_sums[col];
        r.gray_value   = gray_t'(gray);
        r.integral_sum = row_sum + above;
        // A width narrowed in mid-row ends the row at once, because the
        // column may already be at or past the new width.
        r.row_last     = (col + 1 >= w);
        above_row_sums[col]  = r.integral_sum;
        above_row_known[col] = 1'b1;
        pending_results.push_back(r);
        if (r.row_last)
        begin
            next_col = 0;
            row_sum  = '0;
            top_row  = 1'b0;
        end
        else
        begin
            next_col = col + 1;
        end
    endtask

    // This task sends one pixel word. It is called at a falling edge and
    // returns at a falling edge. It leaves valid high, so that a word sent
    // straight after it goes out with no gap. A frame_start is forced where
    // the row above has never been written.
    task automatic push_pixel(input logic fs_req, input byte_t b0, input byte_t b1,
                              input byte_t b2);
        logic fs;
        fs = fs_req || reads_unwritten_entry();
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            pix_if.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        pix_if.valid       = 1'b1;
        pix_if.frame_start = fs;
        pix_if.byte_first  = b0;
        pix_if.byte_second = b1;
        pix_if.byte_third  = b2;
        do
            @(posedge clk);
        while (!pix_if.ready);
        predict_pixel(fs, b0, b1, b2);
        @(negedge clk);
    endtask

    // The sender holds off until every queued result has come back, so that the
    // unit's pipeline is empty as well.
    task automatic wait_for_results();
        pix_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The width register is written only while the unit is idle.
    task automatic write_line_width(input logic [LINE_WIDTH_W-1:0] value);
        wait_for_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        model_width = value;
    endtask

    // Bytes are mostly random, with the two extreme values weighted up.
    function automatic byte_t pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    // Most widths are small, so that many rows end within a short frame. The
    // out-of-range and largest settings come up now and then.
    function automatic logic [LINE_WIDTH_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return LINE_WIDTH_W'(1);
            2:       return '1;
            3:       return LINE_WIDTH_W'(LINE_STORE_DEPTH + 1);
            4:       return LINE_WIDTH_W'(LINE_STORE_DEPTH);
            5, 6, 7: return LINE_WIDTH_W'($urandom_range(13, 80));
            default: return LINE_WIDTH_W'($urandom_range(2, 12));
        endcase
    endfunction

    // A few pixels go in at the reset width, which is 640. The row stays open.
    // The bytes are all zero, then all at full scale, then only the first set.
    task automatic test_reset_width();
        push_pixel(1'b1, 8'h00, 8'h00, 8'h00);
        push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(1'b0, 8'hFF, 8'h00, 8'h00);
    endtask

    // The width is narrowed to 2 while the open row is already at column 3.
    // The next pixel must close that row, and the row after it reads the
    // entries that the open row left in the line store.
    task automatic test_narrowed_row();
        write_line_width(LINE_WIDTH_W'(2));
        push_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
        push_pixel(1'b0, 8'h00, 8'h00, 8'hFF);
        push_pixel(1'b0, 8'h80, 8'h40, 8'h20);
        push_pixel(1'b0, 8'h7F, 8'hBF, 8'hDF);
        push_pixel(1'b0, 8'h01, 8'h02, 8'h04);
    endtask

    // Rows of a single pixel read back the word written by the row before. A
    // width of 0 must behave like a width of 1.
    task automatic test_single_pixel_rows();
        write_line_width(LINE_WIDTH_W'(1));
        push_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
        repeat (4) push_pixel(1'b0, pick_byte(), pick_byte(), pick_byte());
        write_line_width('0);
        repeat (4) push_pixel(1'b0, pick_byte(), pick_byte(), pick_byte());
    endtask

    // A frame_start in mid-row throws away the partial row and the row above.
    task automatic test_frame_restart();
        write_line_width(LINE_WIDTH_W'(3));
        push_pixel(1'b1, 8'h10, 8'h20, 8'h30);
        push_pixel(1'b0, 8'hF0, 8'hE0, 8'hD0);
        push_pixel(1'b1, 8'h55, 8'hAA, 8'h55);
        repeat (4) push_pixel(1'b0, pick_byte(), pick_byte(), pick_byte());
    endtask

    // Random frames come with a fresh width each time. Most start with a
    // frame_start, and a stray restart is inserted now and then. In one phase
    // the sender also pauses in mid-frame until every result is back.
    task automatic test_random_frames();
        int   sent;
        int   n;
        int   phase;
        logic fs;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS)
        begin
            write_line_width(pick_width());
            n = $urandom_range(40, 90);
            for (int k = 0; k < n; k++)
            begin
                if (k == 0)
                    fs = ($urandom_range(0, 3) != 0);
                else
                    fs = ($urandom_range(0, 40) == 0);
                if (phase == 2 && k == n / 2)
                    wait_for_results();
                push_pixel(fs, pick_byte(), pick_byte(), pick_byte());
            end
            sent  += n;
            phase += 1;
        end
    endtask

    // The last part of the run has no idling on either side, so the unit runs
    // back to back at one pixel per cycle.
    task automatic test_full_rate();
        write_line_width(LINE_WIDTH_W'(5));
        idle_enabled = 1'b0;
        push_pixel(1'b1, pick_byte(), pick_byte(), pick_byte());
        repeat (59) push_pixel(1'b0, pick_byte(), pick_byte(), pick_byte());
    endtask

    // The result side stalls in random bursts. Between the bursts it runs ready
    // for a stretch. Ready changes only at falling edges.
    initial
    begin : result_sink
        int   stall_left;
        logic rdy;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!idle_enabled)
            begin
                stall_left = 0;
                rdy        = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left -= 1;
                rdy         = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rdy        = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            res_if.ready = rdy;
        end
    end

    // Each accepted result word is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        pixel_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no pixel waiting: gray_value %0d integral_sum %0d",
                       res_if.gray_value, res_if.integral_sum);
                errors += 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.gray_value !== want.gray_value)
                begin
                    $error("gray_value: expected %0d, actual %0d",
                           want.gray_value, res_if.gray_value);
                    errors += 1;
                end
                if (res_if.integral_sum !== want.integral_sum)
                begin
                    $error("integral_sum: expected %0d, actual %0d",
                           want.integral_sum, res_if.integral_sum);
                    errors += 1;
                end
                if (res_if.row_last !== want.row_last)
                begin
                    $error("row_last: expected %0d, actual %0d",
                           want.row_last, res_if.row_last);
                    errors += 1;
                end
            end
        end
    end

    // The slowest correct run takes well under 2 ms. This limit leaves a wide
    // margin above that.
    initial
    begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        pix_if.valid       = 1'b0;
        pix_if.frame_start = 1'b0;
        pix_if.byte_first  = '0;
        pix_if.byte_second = '0;
        pix_if.byte_third  = '0;

        // After reset the predictor holds the width at its reset value, with a
        // first row pending. No entry of the line store counts as written.
        model_width = LINE_WIDTH_RESET;
        row_sum     = '0;
        next_col    = 0;
        top_row     = 1'b1;
        for (int i = 0; i < LINE_STORE_DEPTH; i++)
        begin
            above_row_sums[i]  = '0;
            above_row_known[i] = 1'b0;
        end

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_width();
        test_narrowed_row();
        test_single_pixel_rows();
        test_frame_restart();
        test_random_frames();
        test_full_rate();

        // Drain the pipeline and keep watching the result side, so that a stray
        // result word would still be caught.
        wait_for_results();
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
